/* src/assert_macros.svh */
// Assertion macros used by the top level of the line blend deinterlacer.
// Depends on nothing; the assertions compile away when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, skipped while in reset.
`define ASSERT_CLK(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("line blend deinterlacer: assertion failed");
// Check that a condition never holds.
`define ASSERT_NEVER(lbl, ck, rs, cond) \
  `ASSERT_CLK(lbl, ck, rs, !(cond))
`else
`define ASSERT_CLK(lbl, ck, rs, prop)
`define ASSERT_NEVER(lbl, ck, rs, cond)
`endif
`endif

/* src/lbdi_pkg.sv */
// Package of the line blend deinterlacer: sizes, register codes, types, blend.
// No dependencies; every RTL file of the block but lbdi_ram imports it.
`timescale 1ns / 1ps
`default_nettype none
package lbdi_pkg;

  localparam int MAX_LINE_WIDTH   = 1024;
  localparam int PAL_FIX_PERIOD   = 25;
  localparam int MAX_FRAME_HEIGHT = 4096;

  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int WID_W = COL_W + 1;
  localparam int ROW_W = 12;
  localparam int HGT_W = 13;
  localparam int PER_W = 5;
  localparam int PER_MAX = 31;

  localparam int PIX_W      = 32;
  localparam int LW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [PIX_W-1:0] BYTE_HALF_MASK = 32'hfefe_fefe;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_FIX      = 2'd2;

  localparam logic [LW_W-1:0] LINE_WIDTH_RESET   = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // Which pixel a source pixel is blended with.
  typedef enum logic [1:0] {
    SEL_SELF,
    SEL_ABOVE,
    SEL_TWO
  } sel_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    sel_t             sel;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] prev_data;
    logic [PIX_W-1:0] older_data;
  } wr_t;

  // Halve each byte and add; no carry can cross a byte boundary.
  function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    blend = ((a & BYTE_HALF_MASK) >> 1) + ((b & BYTE_HALF_MASK) >> 1);
  endfunction

endpackage
`default_nettype wire

/* src/line_blend_deinterlacer.sv */
// Line blend deinterlacer.
// Pixels of a frame enter in raster order on in_valid/in_ready/pixel_in; each
// comes back on out_valid/out_ready as pixel_out, the per-byte average with
// the pixel in the same column one line above (two above on PAL fix lines),
// and frame_last marks the final pixel of the frame.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 line width,
// 1 frame height, 2 PAL fix enable) in the same cycle; settings take effect
// at the next frame's first pixel.
// Throughput: one pixel per clock while in_ready is high. A transaction is
// blended and pushed into the result queue once the registered read of the
// two 1024-entry line stores has returned; the result is offered from then
// on.
// A four-entry result queue sits in front of the output; when the receiver
// stalls, the queue fills and in_ready drops once the queue and the pixel in
// flight would overflow it, then rises again as results drain.
// Reset clears the counters, the queue and restores the register defaults
// (640 by 480, fix off); line store contents are not cleared and are only
// used once written in the current frame.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module line_blend_deinterlacer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lbdi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lbdi_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [lbdi_pkg::PIX_W-1:0]       pixel_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [lbdi_pkg::PIX_W-1:0]       pixel_out,
  output logic                                  frame_last
);
  import lbdi_pkg::*;

  cmd_t              cmd;
  wr_t               wr;
  res_t              res, head;
  logic              take, push;
  logic [PIX_W-1:0]  rd_prev, rd_older;
  logic [QCNT_W-1:0] q_count;

  // Leave room for the pixel still in the back end.
  assign in_ready = (q_count + QCNT_W'(push)) < QCNT_W'(QUEUE_DEPTH);
  assign take     = in_valid && in_ready;

  lbdi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .cmd       (cmd)
  );

  lbdi_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_WIDTH)) u_prev_line (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.prev_data),
    .re    (take),
    .raddr (cmd.col),
    .rdata (rd_prev)
  );

  lbdi_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_WIDTH)) u_older_line (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.older_data),
    .re    (take),
    .raddr (cmd.col),
    .rdata (rd_older)
  );

  lbdi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .cmd      (cmd),
    .pixel_in (pixel_in),
    .rd_prev  (rd_prev),
    .rd_older (rd_older),
    .wr       (wr),
    .push     (push),
    .res      (res)
  );

  lbdi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign pixel_out  = head.pixel;
  assign frame_last = head.last;

  `ASSERT_NEVER(a_queue_no_overflow, clk, rst, push && (q_count == QCNT_W'(QUEUE_DEPTH)) && !(out_valid && out_ready))
  `ASSERT_CLK(a_take_reaches_back, clk, rst, take |=> push)
  `ASSERT_CLK(a_last_restarts_frame, clk, rst, (take && cmd.last) |=> ((cmd.col == '0) && (cmd.sel == SEL_SELF)))

endmodule
`default_nettype wire

/* src/lbdi_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; a read in the cycle of a write returns the old data.
`timescale 1ns / 1ps
`default_nettype none
module lbdi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/lbdi_front.sv */
// Front end: configuration registers, frame/line counters and PAL period logic.
// Classifies each accepted pixel into a command; depends on lbdi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbdi_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lbdi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lbdi_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             take,
  output lbdi_pkg::cmd_t                        cmd
);
  import lbdi_pkg::*;

  logic [LW_W-1:0]  line_width;
  logic [FH_W-1:0]  frame_height;
  logic             pal_fix_enable;

  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [PER_W-1:0] period_count, period_count_next;
  logic [WID_W-1:0] frm_width;
  logic [HGT_W-1:0] frm_height;
  logic             frm_fix;
  logic             use_two_back, use_two_back_next;

  logic             frame_start;
  logic [WID_W-1:0] w_clamp, eff_w;
  logic [HGT_W-1:0] h_clamp, eff_h;
  logic             eff_fix;
  logic [PER_W-1:0] per_base;
  logic             col_wrap, row_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width     <= LINE_WIDTH_RESET;
      frame_height   <= FRAME_HEIGHT_RESET;
      pal_fix_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:   line_width     <= cfg_data[LW_W-1:0];
        REG_FRAME_HEIGHT: frame_height   <= cfg_data[FH_W-1:0];
        REG_PAL_FIX:      pal_fix_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    frame_start = (column_count == '0) && (row_count == '0);

    if (line_width == '0) begin
      w_clamp = WID_W'(1);
    end else if (32'(line_width) > 32'(MAX_LINE_WIDTH)) begin
      w_clamp = WID_W'(MAX_LINE_WIDTH);
    end else begin
      w_clamp = WID_W'(line_width);
    end

    if (frame_height == '0) begin
      h_clamp = HGT_W'(1);
    end else if (32'(frame_height) > 32'(MAX_FRAME_HEIGHT)) begin
      h_clamp = HGT_W'(MAX_FRAME_HEIGHT);
    end else begin
      h_clamp = HGT_W'(frame_height);
    end

    // Settings are sampled at the first pixel of a frame and held after.
    eff_w    = frame_start ? w_clamp : frm_width;
    eff_h    = frame_start ? h_clamp : frm_height;
    eff_fix  = frame_start ? pal_fix_enable : frm_fix;
    per_base = frame_start ? '0 : period_count;

    if (column_count == '0) begin
      use_two_back_next = eff_fix && (per_base == PER_W'(PAL_FIX_PERIOD));
      if (use_two_back_next) begin
        period_count_next = PER_W'(1);
      end else if (per_base < PER_W'(PER_MAX)) begin
        period_count_next = per_base + PER_W'(1);
      end else begin
        period_count_next = per_base;
      end
    end else begin
      use_two_back_next = use_two_back;
      period_count_next = period_count;
    end

    col_wrap = (WID_W'(column_count) + WID_W'(1)) >= eff_w;
    row_wrap = (HGT_W'(row_count) + HGT_W'(1)) >= eff_h;

    if (col_wrap) begin
      column_count_next = '0;
      row_count_next    = row_wrap ? '0 : row_count + ROW_W'(1);
    end else begin
      column_count_next = column_count + COL_W'(1);
      row_count_next    = row_count;
    end

    cmd.col  = column_count;
    cmd.last = col_wrap && row_wrap;
    priority if (row_count == '0) begin
      cmd.sel = SEL_SELF;
    end else if (use_two_back_next && (row_count >= ROW_W'(2))) begin
      cmd.sel = SEL_TWO;
    end else begin
      cmd.sel = SEL_ABOVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      period_count <= '0;
      frm_width    <= '0;
      frm_height   <= '0;
      frm_fix      <= 1'b0;
      use_two_back <= 1'b0;
    end else if (take) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      period_count <= period_count_next;
      frm_width    <= eff_w;
      frm_height   <= eff_h;
      frm_fix      <= eff_fix;
      use_two_back <= use_two_back_next;
    end
  end

endmodule
`default_nettype wire

/* src/lbdi_back.sv */
// Back end: holds the pixel during the line store read, forwards a store
// write to the same column, blends and updates both stores; uses lbdi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbdi_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire lbdi_pkg::cmd_t              cmd,
  input  wire logic [lbdi_pkg::PIX_W-1:0]  pixel_in,
  input  wire logic [lbdi_pkg::PIX_W-1:0]  rd_prev,
  input  wire logic [lbdi_pkg::PIX_W-1:0]  rd_older,
  output lbdi_pkg::wr_t                    wr,
  output logic                             push,
  output lbdi_pkg::res_t                   res
);
  import lbdi_pkg::*;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_px;
  cmd_t             s1_cmd;
  logic             s1_fwd;
  logic [PIX_W-1:0] fwd_prev;
  logic [PIX_W-1:0] fwd_older;

  logic [PIX_W-1:0] above, two, other;

  always_comb begin
    // The store read misses a write made at the same edge: take the bypass.
    above = s1_fwd ? fwd_prev : rd_prev;
    two   = s1_fwd ? fwd_older : rd_older;
    unique case (s1_cmd.sel)
      SEL_SELF:  other = s1_px;
      SEL_TWO:   other = two;
      SEL_ABOVE: other = above;
      default:   other = above;
    endcase

    wr.we         = s1_valid;
    wr.addr       = s1_cmd.col;
    wr.prev_data  = s1_px;
    wr.older_data = above;

    push      = s1_valid;
    res.pixel = blend(s1_px, other);
    res.last  = s1_cmd.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else begin
      s1_valid <= take;
      if (take) begin
        s1_fwd <= s1_valid && (s1_cmd.col == cmd.col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_px     <= pixel_in;
      s1_cmd    <= cmd;
      fwd_prev  <= s1_px;
      fwd_older <= above;
    end
  end

endmodule
`default_nettype wire

/* src/lbdi_queue.sv */
// Short result queue between the back end and the output channel.
// Depends on lbdi_pkg for depth and result type.
`timescale 1ns / 1ps
`default_nettype none
module lbdi_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire lbdi_pkg::res_t               push_data,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output lbdi_pkg::res_t                    head,
  output logic [lbdi_pkg::QCNT_W-1:0]       count
);
  import lbdi_pkg::*;

  res_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic              pop;

  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire
